// ===== sv/upm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package upm_pkg;

  // Longest line that is examined; later characters are dropped.
  localparam int LINE_MAX = 64;

  localparam int CHAR_W = 8;
  localparam int POS_W  = 6;
  localparam int KIND_W = 2;

  localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_LEFT  = 2'd1,
    KIND_RIGHT = 2'd2
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic  accept;  // take the input request and update the line state
    logic  pop;     // drop the top of stack and fetch its position
    logic  load;    // load the output register
    kind_e kind;    // kind of the result being loaded
    logic  last;    // loaded result ends the line
    logic  clear;   // reset the line state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;         // incoming request is an unmatched ')'
    logic end_in;      // incoming request ends the line
    logic end_q;       // accepted request ended the line
    logic depth_zero;  // stack is empty
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== sv/upm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module upm_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  upm_pkg::sts_t   sts_i,
  output upm_pkg::cmd_t   cmd_o
);
  import upm_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RIGHT = 2'd1;
  localparam logic [1:0] ST_END   = 2'd2;
  localparam logic [1:0] ST_POP   = 2'd3;

  logic [1:0] state_q, state_d;

  // Sequence the results of one request
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.kind = KIND_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.hit) begin
            state_d = ST_RIGHT;
          end else if (sts_i.end_in) begin
            state_d = ST_END;
          end
        end
      end
      ST_RIGHT: begin
        if (sts_i.out_free) begin
          cmd_o.load  = 1'b1;
          cmd_o.kind  = KIND_RIGHT;
          cmd_o.last  = sts_i.end_q && sts_i.depth_zero;
          cmd_o.clear = sts_i.end_q && sts_i.depth_zero;
          if (sts_i.end_q && !sts_i.depth_zero) begin
            state_d = ST_END;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_END: begin
        if (!sts_i.depth_zero) begin
          cmd_o.pop = 1'b1;
          state_d   = ST_POP;
        end else if (sts_i.out_free) begin
          cmd_o.load  = 1'b1;
          cmd_o.kind  = KIND_NONE;
          cmd_o.last  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_POP: begin
        if (sts_i.out_free) begin
          cmd_o.load  = 1'b1;
          cmd_o.kind  = KIND_LEFT;
          cmd_o.last  = sts_i.depth_zero;
          cmd_o.clear = sts_i.depth_zero;
          state_d     = sts_i.depth_zero ? ST_IDLE : ST_END;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/upm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module upm_dp #(
  parameter int LineMax = upm_pkg::LINE_MAX
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  [upm_pkg::CHAR_W-1:0]   character_i,
  input  wire                          line_end_i,
  input  wire                          out_ready_i,
  input  upm_pkg::cmd_t                cmd_i,
  output upm_pkg::sts_t                sts_o,
  output logic                         out_valid_o,
  output logic [upm_pkg::POS_W-1:0]    position_o,
  output logic [upm_pkg::KIND_W-1:0]   kind_o,
  output logic                         overflow_o,
  output logic                         last_o
);
  import upm_pkg::*;

  localparam int AW = $clog2(LineMax);
  localparam int DW = $clog2(LineMax + 1);

  // Stack of open bracket positions
  logic [POS_W-1:0] stack_mem [LineMax];
  logic [POS_W-1:0] rd_q;

  logic [DW-1:0]    depth_q, depth_d;
  logic [DW-1:0]    depth_m1;
  logic [DW-1:0]    cnt_q, cnt_d;
  logic             drop_q, drop_d;
  logic             end_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] cur_pos;
  logic             in_range;
  logic             is_open, is_close;
  logic             push;

  logic             out_valid_q, out_valid_d;
  logic [POS_W-1:0] out_pos_q;
  kind_e            out_kind_q;
  logic             out_ovf_q;
  logic             out_last_q;

  // Decode the incoming character
  assign in_range = cnt_q < DW'(LineMax);
  assign cur_pos  = POS_W'(cnt_q);
  assign is_open  = in_range && (character_i == CH_OPEN);
  assign is_close = in_range && (character_i == CH_CLOSE);
  assign depth_m1 = depth_q - DW'(1);
  assign push     = cmd_i.accept && is_open && (depth_q != DW'(LineMax));

  assign sts_o.hit        = is_close && (depth_q == '0);
  assign sts_o.end_in     = line_end_i;
  assign sts_o.end_q      = end_q;
  assign sts_o.depth_zero = (depth_q == '0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Update line state
  always_comb begin
    depth_d = depth_q;
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    if (cmd_i.accept) begin
      if (in_range) begin
        cnt_d = cnt_q + DW'(1);
        if (push) begin
          depth_d = depth_q + DW'(1);
        end else if (is_close && (depth_q != '0)) begin
          depth_d = depth_m1;
        end
      end else begin
        drop_d = 1'b1;
      end
    end else if (cmd_i.pop) begin
      depth_d = depth_m1;
    end
    if (cmd_i.clear) begin
      depth_d = '0;
      cnt_d   = '0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q <= '0;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      end_q   <= 1'b0;
    end else begin
      depth_q <= depth_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      if (cmd_i.accept) begin
        end_q <= line_end_i;
      end
    end
  end

  // Hold the position of each accepted request, used for an unmatched ')'
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pos_q <= cur_pos;
    end
  end

  // Write on push, read the top on pop
  always_ff @(posedge clk_i) begin
    if (push) begin
      stack_mem[depth_q[AW-1:0]] <= cur_pos;
    end
    if (cmd_i.pop) begin
      rd_q <= stack_mem[depth_m1[AW-1:0]];
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      case (cmd_i.kind)
        KIND_RIGHT: out_pos_q <= pos_q;
        KIND_LEFT:  out_pos_q <= rd_q;
        default:    out_pos_q <= '0;
      endcase
      out_kind_q <= cmd_i.kind;
      out_ovf_q  <= drop_q;
      out_last_q <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;
  assign kind_o      = out_kind_q;
  assign overflow_o  = out_ovf_q;
  assign last_o      = out_last_q;

endmodule

`default_nettype wire

// ===== sv/unmatched_paren_marker_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Signals                          Content
// in       input      in_valid_i / in_ready_o          character_i, line_end_i
// out      output     out_valid_o / out_ready_i        position_o, kind_o, overflow_o, last_o
//
// A character that produces no result is taken back to back.
// An unmatched ')' adds a state that loads its result; at line end each open
// '(' left on the stack costs a pop plus the registered stack-memory read,
// a clean line end a single load, all stretched by output stalls.
// Reset is asynchronous, active low; the stack memory needs no clearing.
// A new request is taken while the last result still waits in the output
// register.
module unmatched_paren_marker_unit #(
  parameter int LineMax = upm_pkg::LINE_MAX
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         in_valid_i,
  output logic                        in_ready_o,
  input  wire  [upm_pkg::CHAR_W-1:0]  character_i,
  input  wire                         line_end_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  output logic [upm_pkg::POS_W-1:0]   position_o,
  output logic [upm_pkg::KIND_W-1:0]  kind_o,
  output logic                        overflow_o,
  output logic                        last_o
);
  import upm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  upm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  upm_dp #(
    .LineMax (LineMax)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .character_i (character_i),
    .line_end_i  (line_end_i),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .position_o  (position_o),
    .kind_o      (kind_o),
    .overflow_o  (overflow_o),
    .last_o      (last_o)
  );

  // A line end always yields a result, so the block goes busy
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && line_end_i |=> !in_ready_o)
    else $error("line end accepted without entering the flush");

  // A none result closes the line at position zero
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_NONE) |-> last_o && (position_o == '0))
    else $error("none result without last flag or with nonzero position");

  // Popping only happens with something on the stack
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop |-> !sts.depth_zero && !cmd.accept)
    else $error("pop issued on an empty stack");

endmodule

`default_nettype wire

// ===== sim/bracket_report_checker.sv =====
`timescale 1ns / 1ps

module bracket_report_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [upm_pkg::CHAR_W-1:0]  character_i,
  input  logic                        line_end_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [upm_pkg::POS_W-1:0]   position_i,
  input  logic [upm_pkg::KIND_W-1:0]  kind_i,
  input  logic                        overflow_i,
  input  logic                        last_i,
  output int                          fail_count_o,
  output int                          pending_o
);
  import upm_pkg::*;

  localparam int STACK_SLOTS = 64;
  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic [POS_W-1:0] position;
    kind_e            kind;
    logic             overflow;
    logic             last;
  } bracket_report_t;

  // Results still owed by the block, oldest first
  bracket_report_t expected_reports[$];

  // Own copy of the line state
  logic [POS_W-1:0] open_positions [STACK_SLOTS];
  int unsigned      open_depth;
  int unsigned      char_pos;
  logic             chars_dropped;

  initial begin
    fail_count_o = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count_o < MAX_PRINTED) $display("[%0t] bracket check: %s", $time, what);
    fail_count_o++;
  endtask

  function automatic bracket_report_t make_report(input logic [POS_W-1:0] pos, input kind_e k);
    bracket_report_t r;
    r.position = pos;
    r.kind     = k;
    r.overflow = chars_dropped;
    r.last     = 1'b0;
    return r;
  endfunction

  // Update the line state for one request and queue the results it causes
  task automatic predict_char(input logic [CHAR_W-1:0] ch, input logic ends_line);
    int              n;
    bracket_report_t r;
    n = 0;
    if (char_pos < LINE_MAX) begin
      if (ch == CH_OPEN) begin
        if (open_depth < STACK_SLOTS) begin
          open_positions[open_depth] = char_pos[POS_W-1:0];
          open_depth++;
        end
      end else if (ch == CH_CLOSE) begin
        if (open_depth == 0) begin
          expected_reports.push_back(make_report(char_pos[POS_W-1:0], KIND_RIGHT));
          n++;
        end else begin
          open_depth--;
        end
      end
      char_pos = (char_pos + 1) % 128;
    end else begin
      chars_dropped = 1'b1;
    end

    // Flush the stack at line end, most recent open bracket first
    if (ends_line) begin
      while (open_depth > 0 && n < STACK_SLOTS) begin
        open_depth--;
        expected_reports.push_back(make_report(open_positions[open_depth], KIND_LEFT));
        n++;
      end
      if (n == 0) expected_reports.push_back(make_report('0, KIND_NONE));
      r = expected_reports[expected_reports.size()-1];
      r.last = 1'b1;
      expected_reports[expected_reports.size()-1] = r;
      open_depth    = 0;
      char_pos      = 0;
      chars_dropped = 1'b0;
    end
  endtask

  task automatic check_report();
    bracket_report_t want;
    if (expected_reports.size() == 0) begin
      report_mismatch($sformatf("result with none pending: pos %0d kind %0d ovf %b last %b",
                                position_i, kind_i, overflow_i, last_i));
      return;
    end
    want = expected_reports.pop_front();
    if (position_i !== want.position)
      report_mismatch($sformatf("position %0d, expected %0d", position_i, want.position));
    if (kind_i !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %s at pos %0d",
                                kind_i, want.kind.name(), want.position));
    if (overflow_i !== want.overflow)
      report_mismatch($sformatf("overflow %b, expected %b at pos %0d",
                                overflow_i, want.overflow, want.position));
    if (last_i !== want.last)
      report_mismatch($sformatf("last %b, expected %b at pos %0d",
                                last_i, want.last, want.position));
  endtask

  // Watch both channels
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_reports.delete();
      open_depth    = 0;
      char_pos      = 0;
      chars_dropped = 1'b0;
      pending_o    <= 0;
    end else begin
      // A result accepted now stems from an earlier request, so compare it first
      if (out_valid_i && out_ready_i) check_report();
      if (in_valid_i && in_ready_i) predict_char(character_i, line_end_i);
      pending_o <= expected_reports.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import upm_pkg::*;

  localparam int ITEM_TARGET  = 410;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PAUSE_EVERY  = 120;

  typedef logic [CHAR_W-1:0] line_t[$];

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic [CHAR_W-1:0] character = '0;
  logic              line_end  = 1'b0;
  logic              out_ready = 1'b0;
  logic              in_ready;
  logic              out_valid;
  logic [POS_W-1:0]  position;
  logic [KIND_W-1:0] kind;
  logic              overflow;
  logic              last;

  int fail_count;
  int pending;
  int idle_cycles  = 0;
  int chars_sent   = 0;
  int rx_wait      = 0;
  int rx_calm_left = 0;
  bit tx_calm      = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  unmatched_paren_marker_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .character_i (character),
    .line_end_i  (line_end),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .position_o  (position),
    .kind_o      (kind),
    .overflow_o  (overflow),
    .last_o      (last)
  );

  bracket_report_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .character_i  (character),
    .line_end_i   (line_end),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .position_i   (position),
    .kind_i       (kind),
    .overflow_i   (overflow),
    .last_i       (last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Draw the result-side stall, with occasional stretches of none
  function automatic int draw_rx_stall();
    if (rx_calm_left > 0) begin
      rx_calm_left--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      rx_calm_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  // Hold ready low for a drawn number of cycles after each result
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else if (out_ready && out_valid) begin
      rx_wait = draw_rx_stall();
      out_ready <= (rx_wait == 0);
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= (rx_wait == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Stop a run that makes no progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL unmatched_paren_marker_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [CHAR_W-1:0] filler_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(0, 255)); while (c == CH_OPEN || c == CH_CLOSE);
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] noise_char();
    case ($urandom_range(0, 3))
      0:       return CH_OPEN;
      1:       return CH_CLOSE;
      default: return CHAR_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Nested brackets with filler, closed before the line ends
  function automatic line_t balanced_line();
    line_t q;
    int    depth;
    int    len;
    depth = 0;
    len   = $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          q.push_back(CH_OPEN);
          depth++;
        end
        4, 5, 6: begin
          if (depth > 0) begin
            q.push_back(CH_CLOSE);
            depth--;
          end else begin
            q.push_back(filler_char());
          end
        end
        default: q.push_back(filler_char());
      endcase
    end
    repeat (depth) q.push_back(CH_CLOSE);
    return q;
  endfunction

  // Unbalanced mix of brackets and arbitrary bytes
  function automatic line_t noisy_line();
    line_t q;
    int    len;
    len = $urandom_range(1, 24);
    repeat (len) q.push_back(noise_char());
    return q;
  endfunction

  // Line near, at or past the length limit
  function automatic line_t long_line(input int len, input bit all_open);
    line_t q;
    for (int i = 0; i < len; i++) begin
      if (all_open && i < LINE_MAX) q.push_back(CH_OPEN);
      else q.push_back(noise_char());
    end
    return q;
  endfunction

  function automatic int long_length();
    case ($urandom_range(0, 3))
      0:       return LINE_MAX - 1;
      1:       return LINE_MAX;
      2:       return LINE_MAX + 1;
      default: return $urandom_range(LINE_MAX + 2, LINE_MAX + 8);
    endcase
  endfunction

  // Present one request after a drawn gap and hold it until accepted
  task automatic send_char(input logic [CHAR_W-1:0] ch, input logic ends_line);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    character <= ch;
    line_end  <= ends_line;
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_line(input line_t chars);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
  endtask

  // Hold off requests until every owed result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    line_t dq;
    int    next_pause;
    int    pick;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed lines
    dq = {CH_CLOSE};                            // right bracket on the last character
    send_line(dq);
    dq = {CH_OPEN};
    send_line(dq);
    dq = {8'h00};                               // clean line end
    send_line(dq);
    dq = {8'hFF};
    send_line(dq);
    dq = {CH_OPEN, CH_CLOSE};
    send_line(dq);
    dq = {CH_CLOSE, CH_OPEN};                   // right bracket first, not on the last character
    send_line(dq);
    dq = {CH_OPEN, CH_OPEN, 8'h5A, CH_OPEN};
    send_line(dq);
    dq = {CH_OPEN, CH_CLOSE, CH_CLOSE, CH_CLOSE};
    send_line(dq);
    dq = {8'h27, 8'h2A, CH_OPEN};               // neighbors of the bracket codes
    send_line(dq);
    wait_drained();

    // Full stack with characters dropped past the limit
    dq = long_line($urandom_range(LINE_MAX + 1, LINE_MAX + 6), 1'b1);
    send_line(dq);

    // Random lines, mostly balanced
    next_pause = chars_sent + PAUSE_EVERY;
    while (chars_sent < ITEM_TARGET) begin
      tx_calm = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 15);
      if (pick == 0) dq = long_line(long_length(), 1'($urandom_range(0, 1)));
      else if (pick < 11) dq = balanced_line();
      else dq = noisy_line();
      send_line(dq);
      if (chars_sent >= next_pause) begin
        wait_drained();
        next_pause += PAUSE_EVERY;
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS unmatched_paren_marker_unit");
    end else begin
      $display("FAIL unmatched_paren_marker_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/upm_pkg.sv
sv/upm_ctrl.sv
sv/upm_dp.sv
sv/unmatched_paren_marker_unit.sv
sim/bracket_report_checker.sv
sim/tb.sv
